// ===== design/pml_pkg.sv =====
// Shared constants, status codes and saturation helpers for the plane meeting point solver.
package pml_pkg;

	localparam int MAX_PLANES = 16;
	localparam int CNT_W = 5;
	localparam int PIV_W = 56;
	localparam logic [PIV_W-1:0] MIN_PIVOT_RESET = 56'd72058;
	localparam int TDATA_W = 144;
	localparam int WM_DEPTH = 16;
	localparam int WM_AW = 4;
	localparam int WORD_W = 64;
	localparam int PT_W = 48;

	localparam logic [1:0] ST_SOLVED = 2'd0;
	localparam logic [1:0] ST_SINGULAR = 2'd1;
	localparam logic [1:0] ST_OVERFLOW = 2'd2;

	typedef logic [WORD_W-1:0] word_t;

	// Signed 64-bit a - b, clamped to the signed range
	function automatic word_t sat_sub(input word_t a, input word_t b);
		logic [WORD_W:0] d;
		d = {a[WORD_W-1], a} - {b[WORD_W-1], b};
		if (d[WORD_W] != d[WORD_W-1]) begin
			return d[WORD_W] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
		end
		return d[WORD_W-1:0];
	endfunction

	// Clamp a signed 64-bit value to signed 48 bits
	function automatic logic [PT_W-1:0] sat48(input word_t q);
		if (q[WORD_W-1:PT_W-1] == {(WORD_W-PT_W+1){q[WORD_W-1]}}) begin
			return q[PT_W-1:0];
		end
		return q[WORD_W-1] ? {1'b1, {(PT_W-1){1'b0}}} : {1'b0, {(PT_W-1){1'b1}}};
	endfunction

	// Magnitude of a signed 64-bit value
	function automatic word_t smag(input word_t x);
		return x[WORD_W-1] ? (~x + 64'd1) : x;
	endfunction

endpackage

// ===== design/pml_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pml_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== design/pml_mul32.sv =====
// Shared 32x32 unsigned multiplier with registered product.
module pml_mul32 (
	input  logic        clk,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [63:0] p_q
);

	// Register the product
	always_ff @(posedge clk) begin
		p_q <= 64'(a) * 64'(b);
	end

endmodule

// ===== design/pml_mdiv.sv =====
// Sequenced trunc(a*b/c): four partial products on the shared multiplier, then restoring division.
module pml_mdiv (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  pml_pkg::word_t a,
	input  pml_pkg::word_t b,
	input  pml_pkg::word_t c,
	output logic [31:0]   mul_a,
	output logic [31:0]   mul_b,
	input  logic [63:0]   mul_p,
	output logic          done_q,
	output pml_pkg::word_t q_q
);

	typedef enum logic [3:0] {
		MD_IDLE = 4'b0001,
		MD_MUL  = 4'b0010,
		MD_DIV  = 4'b0100,
		MD_FIN  = 4'b1000
	} md_state_t;

	md_state_t      st_q;
	logic [6:0]     cnt_q;
	pml_pkg::word_t ua_q, ub_q, uc_q, rem_q;
	logic           neg_q;
	logic [127:0]   dvd_q;
	logic [1:0]     pidx;
	logic [127:0]   part;
	logic [64:0]    rem2;
	logic           ge;
	logic           over;
	pml_pkg::word_t mag;

	// Pick the partial product operands by step
	assign mul_a = cnt_q[1] ? ua_q[63:32] : ua_q[31:0];
	assign mul_b = cnt_q[0] ? ub_q[63:32] : ub_q[31:0];

	always_comb begin
		pidx = 2'(cnt_q[2:0] - 3'd1);
		case (pidx)
			2'd0: part = {64'd0, mul_p};
			2'd3: part = {mul_p, 64'd0};
			default: part = {32'd0, mul_p, 32'd0};
		endcase
		rem2 = {rem_q, dvd_q[127]};
		ge = rem2 >= {1'b0, uc_q};
		over = |dvd_q[127:64];
		mag = dvd_q[63:0];
	end

	// Step the product and division sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= MD_IDLE;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				MD_IDLE: begin
					if (start) begin
						ua_q <= pml_pkg::smag(a);
						ub_q <= pml_pkg::smag(b);
						uc_q <= pml_pkg::smag(c);
						neg_q <= a[63] ^ b[63] ^ c[63];
						dvd_q <= '0;
						cnt_q <= '0;
						st_q <= MD_MUL;
					end
				end
				MD_MUL: begin
					if (cnt_q != 7'd0) begin
						dvd_q <= dvd_q + part;
					end
					if (cnt_q == 7'd4) begin
						cnt_q <= '0;
						rem_q <= '0;
						st_q <= MD_DIV;
					end else begin
						cnt_q <= cnt_q + 7'd1;
					end
				end
				MD_DIV: begin
					rem_q <= ge ? 64'(rem2 - {1'b0, uc_q}) : rem2[63:0];
					dvd_q <= {dvd_q[126:0], ge};
					if (cnt_q == 7'd127) begin
						st_q <= MD_FIN;
					end
					cnt_q <= cnt_q + 7'd1;
				end
				MD_FIN: begin
					if (neg_q) begin
						q_q <= (over || mag[63]) ? {1'b1, 63'd0} : (~mag + 64'd1);
					end else begin
						q_q <= (over || mag[63]) ? {1'b0, {63{1'b1}}} : mag;
					end
					done_q <= 1'b1;
					st_q <= MD_IDLE;
				end
				default: st_q <= MD_IDLE;
			endcase
		end
	end

endmodule

// ===== design/plane_meet_least_squares_unit.sv =====
// Top level: plane accumulation, Gauss-Jordan sequencer and result register.
// Each plane updates twelve sums through one shared 32x32 multiplier. On a plane marked
// tlast the 3x3 system is solved in place: the sums are copied to the working RAM, then
// 21 scaled quotients are formed, each by four multiplier passes and a one-bit-per-cycle
// 128/64 divider. The block takes no item while a plane or a solve is in progress; a
// finished result waits in the output register and does not hold up the next item.
// Status in tuser: 0 solved, 1 singular (pivot zero or below min_pivot), 2 more than
// MAX_PLANES planes; points are zero unless solved.
module plane_meet_least_squares_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [55:0]  cfg_wdata,      // min_pivot
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [143:0] s_axis_tdata,   // normal_x, normal_y, normal_z, plane_offset
	input  logic         s_axis_tlast,   // last_plane
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [143:0] m_axis_tdata,   // point_x, point_y, point_z
	output logic [1:0]   m_axis_tuser    // status
);

	typedef enum logic [17:0] {
		S_IDLE = 18'h00001,
		S_ACC  = 18'h00002,
		S_LOAD = 18'h00004,
		S_PRD  = 18'h00008,
		S_PCM  = 18'h00010,
		S_PCHK = 18'h00020,
		S_ROW  = 18'h00040,
		S_RF   = 18'h00080,
		S_RP   = 18'h00100,
		S_KA   = 18'h00200,
		S_KB   = 18'h00400,
		S_KC   = 18'h00800,
		S_KW   = 18'h01000,
		S_FA   = 18'h02000,
		S_FB   = 18'h04000,
		S_FC   = 18'h08000,
		S_FW   = 18'h10000,
		S_OUT  = 18'h20000
	} state_t;

	state_t         st_q;
	logic [pml_pkg::PIV_W-1:0] minpiv_q;
	logic [pml_pkg::CNT_W-1:0] count_q;
	pml_pkg::word_t acc_q [12];
	logic [31:0]    nm_q [3];
	logic [2:0]     ng_q;
	logic [23:0]    dhi_q, dlo_q;
	logic           nd_q, last_q;
	logic [3:0]     idx_q;
	logic [1:0]     ph_q;
	pml_pkg::word_t tmp_q;
	logic [1:0]     col_q, rr_q, r_q, k_q, piv_q;
	logic [1:0]     perm_q [3];
	pml_pkg::word_t best_q, f_q, p_q, b_q, m_q, a_q;
	logic [47:0]    rpt_q [3];
	logic [1:0]     rst_q;
	logic           ovalid_q;
	logic [143:0]   odata_q;
	logic [1:0]     ostat_q;

	// Datapath wires
	logic [1:0]     ar, ak;
	logic [31:0]    acc_b, mul_a, mul_b, md_mul_a, md_mul_b;
	logic [63:0]    mul_p;
	logic           acc_neg;
	pml_pkg::word_t acc_pr, acc_add;
	logic [pml_pkg::WM_AW-1:0] raddr, waddr;
	pml_pkg::word_t rdata, wdata;
	logic           we;
	logic           md_start, md_done;
	pml_pkg::word_t md_a, md_b, md_c, md_q, sub_res, rmag;
	logic [31:0]    in_mag [3];
	logic [47:0]    off_raw, off_mag;

	pml_mul32 u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p_q(mul_p));

	pml_mdiv u_mdiv (
		.clk(clk), .arst_n(arst_n), .start(md_start),
		.a(md_a), .b(md_b), .c(md_c),
		.mul_a(md_mul_a), .mul_b(md_mul_b), .mul_p(mul_p),
		.done_q(md_done), .q_q(md_q)
	);

	pml_ram #(.WIDTH(pml_pkg::WORD_W), .DEPTH(pml_pkg::WM_DEPTH)) u_wm (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	assign s_axis_tready = (st_q == S_IDLE);
	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata = odata_q;
	assign m_axis_tuser = ostat_q;

	// Input magnitudes
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			in_mag[i] = s_axis_tdata[32*i+31] ? (~s_axis_tdata[32*i +: 32] + 32'd1)
				: s_axis_tdata[32*i +: 32];
		end
		off_raw = s_axis_tdata[143:96];
		off_mag = off_raw[47] ? (~off_raw + 48'd1) : off_raw;
	end

	// Accumulation operands and signed update
	always_comb begin
		ar = idx_q[3:2];
		ak = idx_q[1:0];
		case (ak)
			2'd0: begin acc_b = nm_q[0]; acc_neg = ng_q[ar] ^ ng_q[0]; end
			2'd1: begin acc_b = nm_q[1]; acc_neg = ng_q[ar] ^ ng_q[1]; end
			2'd2: begin acc_b = nm_q[2]; acc_neg = ng_q[ar] ^ ng_q[2]; end
			default: begin
				acc_b = (ph_q == 2'd1) ? {8'd0, dlo_q} : {8'd0, dhi_q};
				acc_neg = ng_q[ar] ^ nd_q;
			end
		endcase
		acc_pr = (ak == 2'd3) ? (tmp_q + {22'd0, mul_p[63:22]}) : {4'd0, mul_p[63:4]};
		acc_add = acc_neg ? (64'd0 - acc_pr) : acc_pr;
		mul_a = (st_q == S_ACC) ? nm_q[ar] : md_mul_a;
		mul_b = (st_q == S_ACC) ? acc_b : md_mul_b;
	end

	// Working matrix addressing and quotient requests
	always_comb begin
		case (st_q)
			S_PRD:   raddr = {perm_q[rr_q], col_q};
			S_ROW:   raddr = {perm_q[r_q], col_q};
			S_RF:    raddr = {perm_q[col_q], col_q};
			S_RP:    raddr = {perm_q[col_q], k_q};
			S_KA:    raddr = {perm_q[col_q], k_q};
			S_KB:    raddr = {perm_q[r_q], k_q};
			S_FA:    raddr = {perm_q[r_q], 2'd3};
			S_FB:    raddr = {perm_q[r_q], r_q};
			default: raddr = '0;
		endcase
		sub_res = pml_pkg::sat_sub(m_q, md_q);
		we = (st_q == S_LOAD) || ((st_q == S_KW) && md_done);
		waddr = (st_q == S_LOAD) ? idx_q : {perm_q[r_q], k_q};
		wdata = (st_q == S_LOAD) ? acc_q[idx_q] : sub_res;
		md_start = (st_q == S_KC) || (st_q == S_FC);
		md_a = (st_q == S_KC) ? f_q : a_q;
		md_b = (st_q == S_KC) ? b_q : (64'd1 << 48);
		md_c = (st_q == S_KC) ? p_q : rdata;
		rmag = pml_pkg::smag(rdata);
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			minpiv_q <= pml_pkg::MIN_PIVOT_RESET;
			count_q <= '0;
			for (int i = 0; i < 12; i++) acc_q[i] <= '0;
			idx_q <= '0;
			ph_q <= '0;
			col_q <= '0;
			rr_q <= '0;
			r_q <= '0;
			k_q <= '0;
			piv_q <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				minpiv_q <= cfg_wdata;
			end
			// Release the result on acceptance unless a new one replaces it
			if (ovalid_q && m_axis_tready && st_q != S_OUT) begin
				ovalid_q <= 1'b0;
			end
			case (st_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						for (int i = 0; i < 3; i++) begin
							nm_q[i] <= in_mag[i];
							ng_q[i] <= s_axis_tdata[32*i+31];
						end
						dhi_q <= off_mag[47:24];
						dlo_q <= off_mag[23:0];
						nd_q <= off_raw[47];
						last_q <= s_axis_tlast;
						idx_q <= '0;
						ph_q <= '0;
						if (count_q < pml_pkg::CNT_W'(pml_pkg::MAX_PLANES)) begin
							count_q <= count_q + 1'b1;
							st_q <= S_ACC;
						end else begin
							count_q <= pml_pkg::CNT_W'(pml_pkg::MAX_PLANES + 1);
							if (s_axis_tlast) begin
								rst_q <= pml_pkg::ST_OVERFLOW;
								for (int i = 0; i < 3; i++) rpt_q[i] <= '0;
								st_q <= S_OUT;
							end
						end
					end
				end
				S_ACC: begin
					// Issue, then add; offset terms take a second product
					if (ph_q == 2'd0) begin
						ph_q <= 2'd1;
					end else if (ph_q == 2'd1 && ak == 2'd3) begin
						tmp_q <= {mul_p[61:0], 2'b00};
						ph_q <= 2'd2;
					end else begin
						acc_q[idx_q] <= acc_q[idx_q] + acc_add;
						ph_q <= 2'd0;
						if (idx_q == 4'd11) begin
							idx_q <= '0;
							st_q <= last_q ? S_LOAD : S_IDLE;
						end else begin
							idx_q <= idx_q + 4'd1;
						end
					end
				end
				S_LOAD: begin
					if (idx_q == 4'd11) begin
						perm_q[0] <= 2'd0;
						perm_q[1] <= 2'd1;
						perm_q[2] <= 2'd2;
						col_q <= '0;
						rr_q <= '0;
						st_q <= S_PRD;
					end
					idx_q <= idx_q + 4'd1;
				end
				S_PRD: st_q <= S_PCM;
				S_PCM: begin
					// Keep the first largest magnitude
					if (rr_q == col_q || rmag > best_q) begin
						best_q <= rmag;
						piv_q <= rr_q;
					end
					if (rr_q == 2'd2) begin
						st_q <= S_PCHK;
					end else begin
						rr_q <= rr_q + 2'd1;
						st_q <= S_PRD;
					end
				end
				S_PCHK: begin
					if (best_q == '0 || best_q < {8'd0, minpiv_q}) begin
						rst_q <= pml_pkg::ST_SINGULAR;
						for (int i = 0; i < 3; i++) rpt_q[i] <= '0;
						st_q <= S_OUT;
					end else begin
						// Swap the pivot row in only when it moves
						if (piv_q != col_q) begin
							perm_q[col_q] <= perm_q[piv_q];
							perm_q[piv_q] <= perm_q[col_q];
						end
						r_q <= '0;
						st_q <= S_ROW;
					end
				end
				S_ROW: begin
					k_q <= col_q;
					if (r_q != col_q) begin
						st_q <= S_RF;
					end else if (r_q != 2'd2) begin
						r_q <= r_q + 2'd1;
					end else if (col_q == 2'd2) begin
						r_q <= '0;
						st_q <= S_FA;
					end else begin
						col_q <= col_q + 2'd1;
						rr_q <= col_q + 2'd1;
						st_q <= S_PRD;
					end
				end
				S_RF: begin
					f_q <= rdata;
					st_q <= S_RP;
				end
				S_RP: begin
					p_q <= rdata;
					st_q <= S_KB;
				end
				S_KA: st_q <= S_KB;
				S_KB: begin
					b_q <= rdata;
					st_q <= S_KC;
				end
				S_KC: begin
					m_q <= rdata;
					st_q <= S_KW;
				end
				S_KW: begin
					// Row update written back; move to next column or row, or to the final quotients
					if (md_done) begin
						if (k_q != 2'd3) begin
							k_q <= k_q + 2'd1;
							st_q <= S_KA;
						end else if (r_q != 2'd2) begin
							r_q <= r_q + 2'd1;
							st_q <= S_ROW;
						end else if (col_q == 2'd2) begin
							r_q <= '0;
							st_q <= S_FA;
						end else begin
							col_q <= col_q + 2'd1;
							rr_q <= col_q + 2'd1;
							st_q <= S_PRD;
						end
					end
				end
				S_FA: st_q <= S_FB;
				S_FB: begin
					a_q <= rdata;
					st_q <= S_FC;
				end
				S_FC: st_q <= S_FW;
				S_FW: begin
					if (md_done) begin
						rpt_q[r_q] <= pml_pkg::sat48(md_q);
						if (r_q == 2'd2) begin
							rst_q <= pml_pkg::ST_SOLVED;
							st_q <= S_OUT;
						end else begin
							r_q <= r_q + 2'd1;
							st_q <= S_FA;
						end
					end
				end
				S_OUT: begin
					// Hand over the result once the output register is free, then clear sums
					if (!ovalid_q || m_axis_tready) begin
						odata_q <= {rpt_q[2], rpt_q[1], rpt_q[0]};
						ostat_q <= rst_q;
						ovalid_q <= 1'b1;
						for (int i = 0; i < 12; i++) acc_q[i] <= '0;
						count_q <= '0;
						st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== design/pml_chk.sv =====
// Port-level checker for the plane meeting point solver, bound to the top level.
module pml_chk (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic         s_axis_tlast,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [143:0] m_axis_tdata,
	input logic [1:0]   m_axis_tuser
);

	// Status is one of the three defined codes
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser == pml_pkg::ST_SOLVED ||
			m_axis_tuser == pml_pkg::ST_SINGULAR || m_axis_tuser == pml_pkg::ST_OVERFLOW))
		else $error("bad status code");

	// Failed solves carry a zero point
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser != pml_pkg::ST_SOLVED) |-> (m_axis_tdata == '0))
		else $error("nonzero point with failure status");

	// A last plane is accumulated and solved, or its overflow result is output, so the block is busy the next cycle
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
		else $error("ready right after last plane");

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("result dropped or changed under stall");

endmodule

bind plane_meet_least_squares_unit pml_chk u_pml_chk (
	.clk(clk), .arst_n(arst_n),
	.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready), .s_axis_tlast(s_axis_tlast),
	.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
);

// ===== tb/tb.sv =====
// Self-checking testbench for the plane meeting point solver: directed table, then random plane sets.
`timescale 1ns / 100ps

module tb;

	typedef struct packed {
		logic [47:0] px;
		logic [47:0] py;
		logic [47:0] pz;
		logic [1:0]  status;
	} meet_result_t;

	typedef struct {
		logic [31:0]  nx;
		logic [31:0]  ny;
		logic [31:0]  nz;
		logic [47:0]  offset;
		logic         last;
		logic         typed;
		meet_result_t want;
	} plane_row_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_we = 1'b0;
	logic [55:0]  cfg_wdata = '0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [143:0] s_axis_tdata = '0;   // normal_x, normal_y, normal_z, plane_offset
	logic         s_axis_tlast = 1'b0; // last_plane
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [143:0] m_axis_tdata;        // point_x, point_y, point_z
	logic [1:0]   m_axis_tuser;        // status

	plane_meet_least_squares_unit uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// Model state: running sums, plane count and pivot floor
	logic [63:0]  nn_sum [9];
	logic [63:0]  dn_sum [3];
	int unsigned  planes_taken;
	logic [55:0]  pivot_floor;

	meet_result_t pending_points [$];
	plane_row_t   directed_rows [$];
	int           errors = 0;
	int           planes_sent = 0;
	int           n_solved = 0;
	int           n_singular = 0;
	int           n_overflow = 0;
	int           burst_left = 0;
	bit           hold_request = 1'b0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [63:0] abs64(input logic [63:0] v);
		return v[63] ? (~v + 64'd1) : v;
	endfunction

	// trunc(a*b/c) on the full 128-bit product, clamped to signed 64 bits
	function automatic logic [63:0] scaled_quot(input logic [63:0] a, input logic [63:0] b,
			input logic [63:0] c);
		logic         neg;
		logic [127:0] prod;
		logic [127:0] q;
		neg = a[63] ^ b[63] ^ c[63];
		prod = {64'd0, abs64(a)} * {64'd0, abs64(b)};
		q = prod / {64'd0, abs64(c)};
		if (neg) begin
			if (q[127:64] != 0 || q[63]) return 64'h8000_0000_0000_0000;
			return ~q[63:0] + 64'd1;
		end
		if (q[127:64] != 0 || q[63]) return 64'h7FFF_FFFF_FFFF_FFFF;
		return q[63:0];
	endfunction

	function automatic logic [63:0] clamp_diff(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] d;
		d = {a[63], a} - {b[63], b};
		if (d[64] != d[63]) return d[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
		return d[63:0];
	endfunction

	function automatic logic [47:0] clamp48(input logic [63:0] q);
		if (q[63:47] == {17{q[63]}}) return q[47:0];
		return q[63] ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
	endfunction

	// Gauss-Jordan on the accumulated sums; returns the status and fills the point
	function automatic logic [1:0] solve_meet(output logic [63:0] pt [3]);
		logic [63:0] wm [12];
		logic [63:0] best;
		logic [63:0] tmp;
		logic [63:0] f;
		logic [63:0] p;
		int          piv;
		for (int r = 0; r < 3; r++) begin
			for (int k = 0; k < 3; k++) wm[r*4+k] = nn_sum[r*3+k];
			wm[r*4+3] = dn_sum[r];
			pt[r] = '0;
		end
		for (int col = 0; col < 3; col++) begin
			piv = col;
			best = abs64(wm[col*4+col]);
			for (int r = col + 1; r < 3; r++) begin
				if (abs64(wm[r*4+col]) > best) begin
					best = abs64(wm[r*4+col]);
					piv = r;
				end
			end
			if (best == 0 || best < {8'd0, pivot_floor}) return pml_pkg::ST_SINGULAR;
			if (piv != col) begin
				for (int k = 0; k < 4; k++) begin
					tmp = wm[col*4+k];
					wm[col*4+k] = wm[piv*4+k];
					wm[piv*4+k] = tmp;
				end
			end
			for (int r = 0; r < 3; r++) begin
				if (r != col) begin
					f = wm[r*4+col];
					p = wm[col*4+col];
					for (int k = col; k < 4; k++)
						wm[r*4+k] = clamp_diff(wm[r*4+k], scaled_quot(f, wm[col*4+k], p));
				end
			end
		end
		for (int r = 0; r < 3; r++) pt[r] = scaled_quot(wm[r*4+3], 64'd1 << 48, wm[r*4+r]);
		return pml_pkg::ST_SOLVED;
	endfunction

	// Take one plane into the sums; on the last plane return the expected point
	function automatic bit take_plane(input logic [31:0] nx, input logic [31:0] ny,
			input logic [31:0] nz, input logic [47:0] offset, input logic last,
			output meet_result_t res);
		logic [31:0] comp [3];
		logic [63:0] nm [3];
		logic        ng [3];
		logic [63:0] dm;
		logic [63:0] pr;
		logic [63:0] pt [3];
		logic [1:0]  st;
		comp[0] = nx;
		comp[1] = ny;
		comp[2] = nz;
		res = '0;
		if (planes_taken < pml_pkg::MAX_PLANES) begin
			for (int i = 0; i < 3; i++) begin
				ng[i] = comp[i][31];
				nm[i] = ng[i] ? (64'h1_0000_0000 - {32'd0, comp[i]}) : {32'd0, comp[i]};
			end
			dm = offset[47] ? (64'h1_0000_0000_0000 - {16'd0, offset}) : {16'd0, offset};
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					pr = (nm[i] * nm[j]) >> 4;
					nn_sum[i*3+j] += (ng[i] ^ ng[j]) ? -pr : pr;
				end
				pr = (((dm >> 24) * nm[i]) << 2) + (((dm & 64'hFF_FFFF) * nm[i]) >> 22);
				dn_sum[i] += (offset[47] ^ ng[i]) ? -pr : pr;
			end
			planes_taken++;
		end else begin
			planes_taken = pml_pkg::MAX_PLANES + 1;
		end
		if (!last) return 1'b0;
		if (planes_taken > pml_pkg::MAX_PLANES) begin
			st = pml_pkg::ST_OVERFLOW;
		end else begin
			st = solve_meet(pt);
		end
		if (st == pml_pkg::ST_SOLVED) begin
			res.px = clamp48(pt[0]);
			res.py = clamp48(pt[1]);
			res.pz = clamp48(pt[2]);
		end
		res.status = st;
		for (int i = 0; i < 9; i++) nn_sum[i] = '0;
		for (int i = 0; i < 3; i++) dn_sum[i] = '0;
		planes_taken = 0;
		return 1'b1;
	endfunction

	// Offer one plane request, honoring bursts and gaps, and queue the set's result on its last plane
	task automatic send_plane(input logic [31:0] nx, input logic [31:0] ny,
			input logic [31:0] nz, input logic [47:0] offset, input logic last,
			input logic typed, input meet_result_t want);
		meet_result_t res;
		if (burst_left == 0) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 30)) @(negedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
				: $urandom_range(1, 10);
		end else begin
			@(negedge clk);
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {offset, nz, ny, nx};
		s_axis_tlast <= last;
		do @(posedge clk); while (!s_axis_tready);
		planes_sent++;
		if (take_plane(nx, ny, nz, offset, last, res))
			pending_points = {pending_points, (typed ? want : res)};
	endtask

	// Wait until every result is back and the block has settled, then write the floor
	task automatic set_pivot_floor(input logic [55:0] value);
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_points.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		pivot_floor = value;
		burst_left = 0;
	endtask

	task automatic add_row(input logic [31:0] nx, input logic [31:0] ny, input logic [31:0] nz,
			input logic [47:0] offset, input logic last, input logic typed,
			input meet_result_t want);
		plane_row_t row;
		row.nx = nx;
		row.ny = ny;
		row.nz = nz;
		row.offset = offset;
		row.last = last;
		row.typed = typed;
		row.want = want;
		directed_rows = {directed_rows, row};
	endtask

	function automatic logic [31:0] rand_normal_comp(input int mode);
		if (mode == 0) return $urandom;
		return $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
	endfunction

	// Random plane sets: mostly well-formed, some degenerate, some overflowing
	task automatic run_sets(input int n_planes);
		int          set_len;
		int          mode;
		int          axis;
		logic [31:0] n [3];
		logic [47:0] offset;
		logic [31:0] r;
		int          start;
		start = planes_sent;
		while (planes_sent - start < n_planes) begin
			case ($urandom_range(0, 19))
				0: set_len = $urandom_range(17, 19);
				1: set_len = 16;
				2: set_len = $urandom_range(1, 2);
				default: set_len = $urandom_range(3, 8);
			endcase
			mode = $urandom_range(0, 9);
			axis = $urandom_range(0, 2);
			for (int p = 0; p < set_len; p++) begin
				for (int i = 0; i < 3; i++) n[i] = rand_normal_comp(mode);
				// degenerate sets: every normal along one axis
				if (mode == 1) begin
					n[(axis + 1) % 3] = '0;
					n[(axis + 2) % 3] = '0;
				end
				r = $urandom;
				if (mode == 0 || $urandom_range(0, 15) == 0) begin
					offset = {r[15:0], 32'($urandom)};
				end else begin
					offset = {{16{r[31]}}, r};
				end
				send_plane(n[0], n[1], n[2], offset, p == set_len - 1, 1'b0, '0);
			end
		end
	endtask

	// Receiver stall pattern, with one long hold-off on request
	initial begin
		int stretch;
		stretch = 0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (9000) @(negedge clk);
			end else begin
				stretch = (stretch + 1) % 2000;
				m_axis_tready <= (stretch < 700) ? 1'b1 : ($urandom_range(0, 3) != 0);
			end
		end
	end

	// Check each result request against the oldest expectation
	always @(posedge clk) begin
		meet_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_points.size() == 0) begin
				$display("%0t: unexpected result point %h %h %h status %0d", $realtime,
					m_axis_tdata[47:0], m_axis_tdata[95:48], m_axis_tdata[143:96],
					m_axis_tuser);
				errors++;
			end else begin
				want = pending_points.pop_front();
				if (m_axis_tdata[47:0] !== want.px) begin
					$display("%0t: point_x expected %h actual %h", $realtime, want.px,
						m_axis_tdata[47:0]);
					errors++;
				end
				if (m_axis_tdata[95:48] !== want.py) begin
					$display("%0t: point_y expected %h actual %h", $realtime, want.py,
						m_axis_tdata[95:48]);
					errors++;
				end
				if (m_axis_tdata[143:96] !== want.pz) begin
					$display("%0t: point_z expected %h actual %h", $realtime, want.pz,
						m_axis_tdata[143:96]);
					errors++;
				end
				if (m_axis_tuser !== want.status) begin
					$display("%0t: status expected %0d actual %0d", $realtime, want.status,
						m_axis_tuser);
					errors++;
				end
				case (want.status)
					pml_pkg::ST_SOLVED: n_solved++;
					pml_pkg::ST_SINGULAR: n_singular++;
					default: n_overflow++;
				endcase
			end
		end
	end

	// Stimulus
	initial begin
		meet_result_t w;
		int           wait_cycles;
		for (int i = 0; i < 9; i++) nn_sum[i] = '0;
		for (int i = 0; i < 3; i++) dn_sum[i] = '0;
		planes_taken = 0;
		pivot_floor = pml_pkg::MIN_PIVOT_RESET;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// axis planes meet exactly at their offsets
		add_row(32'h4000_0000, 32'd0, 32'd0, 48'sd5 <<< 16, 1'b0, 1'b0, '0);
		add_row(32'd0, 32'h4000_0000, 32'd0, -(48'sd3 <<< 16), 1'b0, 1'b0, '0);
		w = '{px: 48'sd5 <<< 16, py: -(48'sd3 <<< 16), pz: 48'sd7 <<< 16,
			status: pml_pkg::ST_SOLVED};
		add_row(32'd0, 32'd0, 32'h4000_0000, 48'sd7 <<< 16, 1'b1, 1'b1, w);
		// offset extremes with negative normals; y saturates
		add_row(32'hC000_0000, 32'd0, 32'd0, 48'h7FFF_FFFF_FFFF, 1'b0, 1'b0, '0);
		add_row(32'd0, 32'hC000_0000, 32'd0, 48'h8000_0000_0000, 1'b0, 1'b0, '0);
		w = '{px: 48'h8000_0000_0001, py: 48'h7FFF_FFFF_FFFF, pz: '0,
			status: pml_pkg::ST_SOLVED};
		add_row(32'd0, 32'd0, 32'h4000_0000, 48'd0, 1'b1, 1'b1, w);
		// fewer than three planes, and a zero normal: singular
		w = '{px: '0, py: '0, pz: '0, status: pml_pkg::ST_SINGULAR};
		add_row(32'h4000_0000, 32'd0, 32'd0, 48'sd1 <<< 16, 1'b1, 1'b1, w);
		add_row(32'd0, 32'd0, 32'd0, 48'd0, 1'b1, 1'b1, w);
		// out-of-range normal codes taken as two's complement
		add_row(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 48'h0000_1234_5678, 1'b0, 1'b0,
			'0);
		add_row(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 48'hFFFF_0000_0001, 1'b0, 1'b0,
			'0);
		add_row(32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000, 48'h0000_8000_0000, 1'b1, 1'b0,
			'0);
		// one plane more than the set can hold
		for (int i = 0; i < pml_pkg::MAX_PLANES; i++)
			add_row(32'h4000_0000, 32'd0, 32'd0, 48'd0, 1'b0, 1'b0, '0);
		w = '{px: '0, py: '0, pz: '0, status: pml_pkg::ST_OVERFLOW};
		add_row(32'd0, 32'h4000_0000, 32'd0, 48'd0, 1'b1, 1'b1, w);

		foreach (directed_rows[i])
			send_plane(directed_rows[i].nx, directed_rows[i].ny, directed_rows[i].nz,
				directed_rows[i].offset, directed_rows[i].last, directed_rows[i].typed,
				directed_rows[i].want);

		// random phases across pivot floors, extremes included
		set_pivot_floor('0);
		send_plane(32'd0, 32'd0, 32'd0, 48'h0000_0001_0000, 1'b1, 1'b0, '0);
		run_sets(330);
		set_pivot_floor(56'hFF_FFFF_FFFF_FFFF);
		run_sets(200);
		set_pivot_floor(56'({$urandom, $urandom}));
		run_sets(150);
		hold_request = 1'b1;
		run_sets(200);
		set_pivot_floor(56'({$urandom_range(0, 255), 24'd0}));
		run_sets(400);
		set_pivot_floor(pml_pkg::MIN_PIVOT_RESET);
		run_sets(400);

		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		s_axis_tlast <= 1'b0;
		wait_cycles = 0;
		while (pending_points.size() != 0 && wait_cycles < 200000) begin
			@(negedge clk);
			wait_cycles++;
		end
		repeat (200) @(negedge clk);
		if (pending_points.size() != 0) begin
			$display("%0t: %0d results never arrived", $realtime, pending_points.size());
			errors++;
		end
		$display("Sent %0d planes; results: %0d solved, %0d singular, %0d overflow.",
			planes_sent, n_solved, n_singular, n_overflow);
		$display("Pivot floors covered zero, full scale, reset value and random settings.");
		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#200_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule

// ===== sim.f =====
design/pml_pkg.sv
design/pml_ram.sv
design/pml_mul32.sv
design/pml_mdiv.sv
design/plane_meet_least_squares_unit.sv
design/pml_chk.sv
tb/tb.sv
